// ===== design/lpssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpssd_pkg: shared types and helpers for the light pulse sync/sweep decoder
// Beat payload structs, edge and register codes, and the axis parity helper.
// ----------------------------------------------------------------------------
package lpssd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 3;

  localparam logic [ThreshW-1:0] ThresholdReset = 16'd800;

  // A step of 160 ticks is 32 * 5, so the quotient is (w >> 5) / 5.
  localparam int unsigned StepShift = 5;
  localparam int unsigned QuotW     = TimeW - StepShift;

  typedef enum logic {
    EdgeFall = 1'b0,
    EdgeRise = 1'b1
  } edge_e;

  typedef enum logic {
    RegSweepThreshold = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic             req_type;
    logic [TimeW-1:0] edge_time;
  } req_t;

  typedef struct packed {
    logic [TimeW-1:0] x_interval;
    logic [TimeW-1:0] y_interval;
    logic [TimeW-1:0] pulse_width;
    logic             is_sweep;
    logic             axis_is_x;
    logic [TimeW-1:0] extra_falls;
  } rsp_t;

  typedef struct packed {
    logic pulse_open;
    logic measure_armed;
  } status_t;

  // Remainder by five of a value up to 127. Since 16 is 1 mod 5, the upper
  // bits fold onto the low nibble before a short compare chain.
  function automatic logic [2:0] mod5(input logic [6:0] s);
    logic [4:0] f;
    f = {1'b0, s[3:0]} + {2'b00, s[6:4]};
    if (f >= 5'd20) begin
      f = f - 5'd20;
    end else if (f >= 5'd15) begin
      f = f - 5'd15;
    end else if (f >= 5'd10) begin
      f = f - 5'd10;
    end else if (f >= 5'd5) begin
      f = f - 5'd5;
    end
    return f[2:0];
  endfunction

  // True when floor(w / 160) is even. The quotient's parity follows from
  // (w >> 5) mod 10, built from its residues mod 2 and mod 5; the mod 5
  // residue comes from the sum of hex digits.
  function automatic logic axis_even(input logic [TimeW-1:0] w);
    logic [QuotW-1:0] q;
    logic [27:0]      qe;
    logic [6:0]       acc;
    logic [2:0]       r5;
    q   = w[TimeW-1:StepShift];
    qe  = {1'b0, q};
    acc = '0;
    for (int i = 0; i < 7; i++) begin
      acc = acc + {3'b000, qe[4*i +: 4]};
    end
    r5 = mod5(acc);
    return ~(q[0] ^ r5[0]);
  endfunction

endpackage

// ===== design/lpssd_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpssd_apb_regs: configuration register file
// Holds the sweep threshold behind an APB-style port with no wait states.
// ----------------------------------------------------------------------------
module lpssd_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpssd_pkg::AddrW-1:0]       paddr,
  input  logic [lpssd_pkg::DataW-1:0]       pwdata,
  output logic [lpssd_pkg::DataW-1:0]       prdata,
  output logic                              pready,
  output logic [lpssd_pkg::ThreshW-1:0]     threshold_o
);

  logic [lpssd_pkg::ThreshW-1:0] thresh_q, thresh_d;
  logic                          wr_en;

  // Only the word index matters; the byte offset bits are ignored.
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lpssd_pkg::RegSweepThreshold);
  assign pready = 1'b1;

  always_comb begin
    thresh_d = thresh_q;
    if (wr_en) begin
      thresh_d = pwdata[lpssd_pkg::ThreshW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= lpssd_pkg::ThresholdReset;
    end else begin
      thresh_q <= thresh_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == lpssd_pkg::RegSweepThreshold) begin
      prdata = {{(lpssd_pkg::DataW - lpssd_pkg::ThreshW){1'b0}}, thresh_q};
    end
  end

  assign threshold_o = thresh_q;

endmodule

// ===== design/lpssd_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpssd_in_reg: input register
// Captures one edge beat and holds it until the decoder core takes it.
// ----------------------------------------------------------------------------
module lpssd_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpssd_pkg::req_t   in_data_i,
  output logic              stage_valid_o,
  output lpssd_pkg::req_t   stage_data_o,
  input  logic              stage_take_i
);

  logic            valid_q, valid_d;
  lpssd_pkg::req_t data_q, data_d;
  logic            load;

  // The register refills in the same cycle that the core drains it.
  assign in_ready_o = !valid_q || stage_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = in_data_i;
    end else if (stage_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign stage_valid_o = valid_q;
  assign stage_data_o  = data_q;

endmodule

// ===== design/lpssd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpssd_core: pulse tracking state and result register
// Applies one edge per unstalled cycle and registers the status beat.
// ----------------------------------------------------------------------------
module lpssd_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           stage_valid_i,
  input  lpssd_pkg::req_t                stage_data_i,
  output logic                           stage_take_o,
  input  logic [lpssd_pkg::ThreshW-1:0]  threshold_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output lpssd_pkg::rsp_t                out_data_o,
  output lpssd_pkg::status_t             status_o
);

  localparam int unsigned TW = lpssd_pkg::TimeW;

  logic          open_q, open_d;
  logic          armed_q, armed_d;
  logic          axis_q, axis_d;
  logic          sweep_q, sweep_d;
  logic [TW-1:0] start_q, start_d;
  logic [TW-1:0] prev_q, prev_d;
  logic [TW-1:0] ival_q, ival_d;
  logic [TW-1:0] x_q, x_d;
  logic [TW-1:0] y_q, y_d;
  logic [TW-1:0] width_q, width_d;
  logic [TW-1:0] falls_q, falls_d;

  logic            out_valid_q, out_valid_d;
  lpssd_pkg::rsp_t out_data_q, out_data_d;

  logic          take;
  logic [TW-1:0] t;
  logic [TW-1:0] w;

  assign take         = stage_valid_i && (!out_valid_q || out_ready_i);
  assign stage_take_o = take;
  assign t            = stage_data_i.edge_time;
  assign w            = t - start_q;

  always_comb begin
    open_d  = open_q;
    armed_d = armed_q;
    axis_d  = axis_q;
    sweep_d = sweep_q;
    start_d = start_q;
    prev_d  = prev_q;
    ival_d  = ival_q;
    x_d     = x_q;
    y_d     = y_q;
    width_d = width_q;
    falls_d = falls_q;
    if (take) begin
      if (stage_data_i.req_type == lpssd_pkg::EdgeFall) begin
        if (!open_q) begin
          start_d = t;
          open_d  = 1'b1;
          if (armed_q) begin
            ival_d = t - prev_q;
          end
          // The held interval is filed again even when nothing was armed.
          if (axis_q) begin
            x_d = ival_d;
          end else begin
            y_d = ival_d;
          end
          prev_d = t;
        end else begin
          falls_d = falls_q + TW'(1);
        end
      end else if (open_q) begin
        open_d  = 1'b0;
        width_d = w;
        sweep_d = (w < {{(TW - lpssd_pkg::ThreshW){1'b0}}, threshold_i});
        if (sweep_d) begin
          armed_d = 1'b0;
        end else begin
          armed_d = 1'b1;
          axis_d  = lpssd_pkg::axis_even(w);
        end
      end
    end
  end

  always_comb begin
    out_data_d             = out_data_q;
    out_valid_d            = out_valid_q;
    if (take) begin
      out_valid_d             = 1'b1;
      out_data_d.x_interval   = x_d;
      out_data_d.y_interval   = y_d;
      out_data_d.pulse_width  = width_d;
      out_data_d.is_sweep     = sweep_d;
      out_data_d.axis_is_x    = axis_d;
      out_data_d.extra_falls  = falls_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      armed_q     <= 1'b0;
      axis_q      <= 1'b0;
      sweep_q     <= 1'b0;
      start_q     <= '0;
      prev_q      <= '0;
      ival_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      width_q     <= '0;
      falls_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      armed_q     <= armed_d;
      axis_q      <= axis_d;
      sweep_q     <= sweep_d;
      start_q     <= start_d;
      prev_q      <= prev_d;
      ival_q      <= ival_d;
      x_q         <= x_d;
      y_q         <= y_d;
      width_q     <= width_d;
      falls_q     <= falls_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o               = out_data_q;
  assign status_o.pulse_open      = open_q;
  assign status_o.measure_armed   = armed_q;

endmodule

// ===== design/light_pulse_sync_sweep_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pulse_sync_sweep_decoder: photodiode pulse sync/sweep decoder
// Tracks optical pulses from timestamped edges and reports one status beat
// per edge: axis intervals, last pulse width, sweep flag, axis, extra falls.
//
//   Channel   Direction  Signals                              Beat
//   in        sink       in_valid_i / in_ready_o / in_data_i    one edge
//   out       source     out_valid_o / out_ready_i / out_data_o one status
//   config    slave      psel penable pwrite paddr pwdata ...   register access
//
// An edge beat waits in the input register until the core takes it, and its
// status beat is then registered. One edge per cycle is sustained unless
// the output stalls; the single state update per cycle sets it.
// Reset clears all pulse state and loads the threshold with 800 ticks.
// While the result register holds an untaken beat, no new edge is taken
// from the input register, which can still hold one further edge.
// ----------------------------------------------------------------------------
module light_pulse_sync_sweep_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lpssd_pkg::req_t             in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lpssd_pkg::rsp_t             out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpssd_pkg::AddrW-1:0] paddr,
  input  logic [lpssd_pkg::DataW-1:0] pwdata,
  output logic [lpssd_pkg::DataW-1:0] prdata,
  output logic                        pready
);

  logic                          stage_valid;
  lpssd_pkg::req_t               stage_data;
  logic                          stage_take;
  logic [lpssd_pkg::ThreshW-1:0] threshold;
  lpssd_pkg::status_t            status;

  lpssd_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold)
  );

  lpssd_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .stage_valid_o (stage_valid),
    .stage_data_o  (stage_data),
    .stage_take_i  (stage_take)
  );

  lpssd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid),
    .stage_data_i  (stage_data),
    .stage_take_o  (stage_take),
    .threshold_i   (threshold),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .status_o      (status)
  );

  // An empty input register always accepts.
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid |-> in_ready_o)
    else $error("input register empty but not ready");

  // Every edge taken by the core yields a status beat next cycle.
  a_take_gives_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_take |=> out_valid_o)
    else $error("taken edge produced no status beat");

  // A stalled result blocks the core from taking another edge.
  a_no_take_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !stage_take)
    else $error("edge taken while result stalled");

  // A rising edge on an open pulse always closes it.
  a_rise_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_take && (stage_data.req_type == lpssd_pkg::EdgeRise) && status.pulse_open)
      |=> !status.pulse_open)
    else $error("rising edge did not close the pulse");

endmodule
